FILE: design/combination_enumerator_defines.svh
// ---------------------------------------------------------------------------
// Combination enumerator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef COMBINATION_ENUMERATOR_DEFINES_SVH
`define COMBINATION_ENUMERATOR_DEFINES_SVH

// Same-cycle implication
`define CMBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CMBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/cmbe_pkg.sv
// ---------------------------------------------------------------------------
// Combination enumerator package
// Widths, register indexes and shared types of the enumerator.
// ---------------------------------------------------------------------------
`default_nettype none

package cmbe_pkg;

  localparam int DEF_MAX_OBJECTS = 64;
  localparam int DEF_MAX_CHOSEN  = 16;

  localparam int N_W        = 7;
  localparam int K_W        = 5;
  localparam int ELEM_W     = 6;
  localparam int POS_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOSEN = 2'd1;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic [N_W-1:0] n;
    logic [K_W-1:0] k;
    logic           ok;   // n and k form a legal pair
    logic           wr;   // a register is being written this cycle
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/cmbe_if.sv
// ---------------------------------------------------------------------------
// Combination enumerator channels
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface cmbe_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cmbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [cmbe_pkg::ELEM_W-1:0] element;
  logic [cmbe_pkg::POS_W-1:0]  position;
  logic                        last;
  logic                        has_combination;

  modport source (output valid, output element, output position, output last,
                  output has_combination, input ready);
  modport sink   (input valid, input element, input position, input last,
                  input has_combination, output ready);
endinterface

interface cmbe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cmbe_pkg::CFG_IDX_W-1:0]  index;
  logic [cmbe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/cmbe_mem.sv
// ---------------------------------------------------------------------------
// Combination enumerator position store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cmbe_mem #(
  parameter int DEPTH = cmbe_pkg::DEF_MAX_CHOSEN,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [IDX_W-1:0]                  waddr,
  input  wire  [cmbe_pkg::ELEM_W-1:0]       wdata,
  input  wire  [IDX_W-1:0]                  raddr,
  output logic [cmbe_pkg::ELEM_W-1:0]       rdata
);
  import cmbe_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/cmbe_seq.sv
// ---------------------------------------------------------------------------
// Combination enumerator sequencer
// Scans, bumps and refills the positions with its compare and increment
// logic, then streams the combination out of a result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "combination_enumerator_defines.svh"

module cmbe_seq #(
  parameter int MAX_CHOSEN = cmbe_pkg::DEF_MAX_CHOSEN,
  parameter int IDX_W      = (MAX_CHOSEN > 1) ? $clog2(MAX_CHOSEN) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  cmbe_pkg::cfg_t         cfg,
  cmbe_in_if.sink                      in_ch,
  cmbe_out_if.source                   out_ch,
  output logic                         mem_we,
  output logic [IDX_W-1:0]             mem_addr,
  output logic [cmbe_pkg::ELEM_W-1:0]  mem_wdata,
  input  wire  [cmbe_pkg::ELEM_W-1:0]  mem_rdata
);
  import cmbe_pkg::*;

  localparam int CMP_W = 8;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_CMP = 7'b0000100,
    S_FILL     = 7'b0001000,
    S_EMIT_RD  = 7'b0010000,
    S_EMIT_LD  = 7'b0100000,
    S_NONE     = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ELEM_W-1:0]   val_r, val_nxt;
  logic                started_r, started_nxt;

  logic                out_valid_r;
  logic [ELEM_W-1:0]   element_r;
  logic [POS_W-1:0]    position_r;
  logic                last_r;
  logic                has_r;

  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    k_last;
  logic [CMP_W-1:0]    limit;
  logic                at_last;
  logic                out_free;
  logic                load;
  logic                ld_none;

  assign idx_ext  = CMP_W'(idx_r);
  assign k_last   = CMP_W'(cfg.k) - CMP_W'(1);
  assign limit    = CMP_W'(cfg.n) - CMP_W'(cfg.k) + idx_ext;
  assign at_last  = (idx_ext == k_last);
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);
  assign mem_addr    = idx_r;
  assign mem_wdata   = val_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    started_nxt = started_r;
    mem_we      = 1'b0;
    load        = 1'b0;
    ld_none     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.restart) begin
            if (cfg.ok) begin
              started_nxt = 1'b1;
              idx_nxt     = '0;
              val_nxt     = '0;
              state_nxt   = S_FILL;
            end else begin
              started_nxt = 1'b0;
              state_nxt   = S_NONE;
            end
          end else if (started_r && cfg.ok) begin
            idx_nxt   = IDX_W'(k_last);
            state_nxt = S_SCAN_RD;
          end else begin
            state_nxt = S_NONE;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (CMP_W'(mem_rdata) >= limit) begin
          // entry at its maximum: move one position left, or run out
          if (idx_r == '0) begin
            state_nxt = S_NONE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_SCAN_RD;
          end
        end else begin
          val_nxt   = mem_rdata + ELEM_W'(1);
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          val_nxt = val_r + ELEM_W'(1);
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          load = 1'b1;
          if (at_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_NONE: begin
        if (out_free) begin
          load      = 1'b1;
          ld_none   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a register write drops the running enumeration
    if (cfg.wr) begin
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    if (load) begin
      element_r  <= ld_none ? '0 : mem_rdata;
      position_r <= ld_none ? '0 : idx_ext[POS_W-1:0];
      last_r     <= ld_none || at_last;
      has_r      <= !ld_none;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.element         = element_r;
  assign out_ch.position        = position_r;
  assign out_ch.last            = last_r;
  assign out_ch.has_combination = has_r;

  `CMBE_ASSERT_NXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after request")
  `CMBE_ASSERT_IMP(a_none_is_last, out_valid_r && !has_r, last_r, "no-combination result not last")
  `CMBE_ASSERT_NXT(a_cfg_clears_started, cfg.wr, !started_r, "started kept over config write")
  `CMBE_ASSERT_NXT(a_load_shows, (state_r == S_EMIT_LD) && out_free, out_valid_r, "result lost")

endmodule

`default_nettype wire

FILE: design/combination_enumerator.sv
// ---------------------------------------------------------------------------
// Combination enumerator
// Lexicographic k-of-n combination generator with register configuration.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_ch writes n (index 0) and k (index 1); it is always ready. A write to
//   either register drops the running enumeration, so follow it with a
//   restart request. Writes to other indexes are dropped.
//   in_ch carries one request: restart=1 loads 0..k-1, restart=0 steps to
//   the next combination. Each request yields k results on out_ch, one per
//   position, last on the final one; an exhausted or illegal setup yields a
//   single result with has_combination=0, and the positions are kept.
//   One request is in flight at a time. A restart fills the k positions and
//   then emits them; a step scans from the last position leftwards to the
//   first one that can move, bumps it, refills the positions to its right
//   and then emits all k; an exhausted step scans every position. Each
//   scanned or emitted position waits on the registered read port of the
//   position store.
//   Results leave through a result register; a stalled receiver holds the
//   sequencer, and in_ch turns ready once the last result sits in it.
//   Reset (rst_n low, synchronous) sets n=1, k=1 and clears the enumeration.
// ---------------------------------------------------------------------------
`default_nettype none

module combination_enumerator #(
  parameter int MAX_OBJECTS = cmbe_pkg::DEF_MAX_OBJECTS,
  parameter int MAX_CHOSEN  = cmbe_pkg::DEF_MAX_CHOSEN
) (
  input  wire         clk,
  input  wire         rst_n,
  cmbe_cfg_if.sink    cfg_ch,
  cmbe_in_if.sink     in_ch,
  cmbe_out_if.source  out_ch
);
  import cmbe_pkg::*;

  localparam int IDX_W = (MAX_CHOSEN > 1) ? $clog2(MAX_CHOSEN) : 1;

  logic [N_W-1:0]    n_r;
  logic [K_W-1:0]    k_r;
  cfg_t              cfg;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_addr;
  logic [ELEM_W-1:0] mem_wdata;
  logic [ELEM_W-1:0] mem_rdata;
  logic              wr_hit;

  assign cfg_ch.ready = 1'b1;
  assign wr_hit = cfg_ch.valid && ((cfg_ch.index == REG_TOTAL) || (cfg_ch.index == REG_CHOSEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= N_W'(1);
      k_r <= K_W'(1);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TOTAL) begin
        n_r <= cfg_ch.data[N_W-1:0];
      end else if (cfg_ch.index == REG_CHOSEN) begin
        k_r <= cfg_ch.data[K_W-1:0];
      end
    end
  end

  assign cfg.n  = n_r;
  assign cfg.k  = k_r;
  assign cfg.ok = (k_r != '0) && (int'(k_r) <= MAX_CHOSEN) &&
                  (n_r != '0) && (int'(n_r) <= MAX_OBJECTS) &&
                  (N_W'(k_r) <= n_r);
  assign cfg.wr = wr_hit;

  cmbe_seq #(
    .MAX_CHOSEN (MAX_CHOSEN),
    .IDX_W      (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cmbe_mem #(
    .DEPTH (MAX_CHOSEN),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: sim/combination_enumerator_checker.sv
// ---------------------------------------------------------------------------
// Combination enumerator result checker
// Watches the register, request and result channels, keeps its own copy of
// the k-of-n enumeration, predicts the results of every accepted request and
// compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module combination_enumerator_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [cmbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cmbe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_restart,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [cmbe_pkg::ELEM_W-1:0]      out_element,
  input  logic [cmbe_pkg::POS_W-1:0]       out_position,
  input  logic                             out_last,
  input  logic                             out_has_combination,
  output int unsigned                      fail_count,
  output int unsigned                      backlog
);
  import cmbe_pkg::*;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [POS_W-1:0]  position;
    logic              last;
    logic              has_combination;
  } result_t;

  result_t           expected_q[$];
  result_t           oldest;
  logic [N_W-1:0]    obj_total;
  logic [K_W-1:0]    pick_count;
  logic [ELEM_W-1:0] combo[DEF_MAX_CHOSEN];
  bit                running;

  function automatic result_t make_result(input logic [ELEM_W-1:0] element,
                                          input int position, input bit last,
                                          input bit has_combination);
    result_t r;
    r.element         = element;
    r.position        = POS_W'(position);
    r.last            = last;
    r.has_combination = has_combination;
    return r;
  endfunction

  function automatic bit setup_legal();
    return pick_count >= 1 && pick_count <= DEF_MAX_CHOSEN &&
           obj_total >= 1 && obj_total <= DEF_MAX_OBJECTS &&
           pick_count <= obj_total;
  endfunction

  task automatic queue_combination();
    int kk;
    int p;
    kk = pick_count;
    for (p = 0; p < kk; p++)
      expected_q.push_back(make_result(combo[p], p, p == kk - 1, 1'b1));
  endtask

  task automatic predict_request(input logic restart);
    int kk;
    int nn;
    int i;
    int m;
    kk = pick_count;
    nn = obj_total;
    if (restart && !setup_legal()) begin
      running = 1'b0;
      expected_q.push_back(make_result('0, 0, 1'b1, 1'b0));
    end else if (restart) begin
      for (i = 0; i < kk; i++)
        combo[i] = ELEM_W'(i);
      running = 1'b1;
      queue_combination();
    end else if (!running || !setup_legal()) begin
      expected_q.push_back(make_result('0, 0, 1'b1, 1'b0));
    end else begin
      // find the rightmost position that can still move
      i = kk - 1;
      while (i >= 0 && int'(combo[i]) >= nn - kk + i)
        i--;
      if (i < 0) begin
        expected_q.push_back(make_result('0, 0, 1'b1, 1'b0));
      end else begin
        combo[i] = combo[i] + 1'b1;
        for (m = i + 1; m < kk; m++)
          combo[m] = combo[m - 1] + 1'b1;
        queue_combination();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      obj_total  = N_W'(1);
      pick_count = K_W'(1);
      running    = 1'b0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOTAL) begin
          obj_total = cfg_data[N_W-1:0];
          running   = 1'b0;
        end else if (cfg_index == REG_CHOSEN) begin
          pick_count = cfg_data[K_W-1:0];
          running    = 1'b0;
        end
      end
      if (in_valid && in_ready)
        predict_request(in_restart);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: element %0d position %0d",
                 out_element, out_position);
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          if (out_element !== oldest.element) begin
            $error("element: expected %0d, actual %0d", oldest.element, out_element);
            fail_count++;
          end
          if (out_position !== oldest.position) begin
            $error("position: expected %0d, actual %0d", oldest.position, out_position);
            fail_count++;
          end
          if (out_last !== oldest.last) begin
            $error("last: expected %0d, actual %0d", oldest.last, out_last);
            fail_count++;
          end
          if (out_has_combination !== oldest.has_combination) begin
            $error("has_combination: expected %0d, actual %0d",
                   oldest.has_combination, out_has_combination);
            fail_count++;
          end
        end
      end
    end
    backlog = expected_q.size();
  end

endmodule

`default_nettype wire

FILE: sim/combination_enumerator_test.sv
// ---------------------------------------------------------------------------
// Combination enumerator regression
// Drives register writes and restart/advance requests into the enumerator
// with random idling on both sides, and lets the checker compare every
// result against its own enumeration of the k-of-n combinations.
// ---------------------------------------------------------------------------
`default_nettype none

module combination_enumerator_test;
  import cmbe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam bit RESTART = 1'b1;
  localparam bit ADVANCE = 1'b0;

  localparam int RANDOM_REQUESTS = 285;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 100;
  localparam int LIMIT_CYCLES    = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned backlog;
  int unsigned random_sent;

  cmbe_in_if  in_ch();
  cmbe_out_if out_ch();
  cmbe_cfg_if cfg_ch();

  combination_enumerator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  combination_enumerator_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_ch.valid),
    .cfg_ready           (cfg_ch.ready),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_restart          (in_ch.restart),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_element         (out_ch.element),
    .out_position        (out_ch.position),
    .out_last            (out_ch.last),
    .out_has_combination (out_ch.has_combination),
    .fail_count          (fail_count),
    .backlog             (backlog)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_taken  <= in_ch.valid & in_ch.ready;
    cfg_taken <= cfg_ch.valid & cfg_ch.ready;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("combination_enumerator regression: fail");
      $finish;
    end
  end

  // Hold valid high until the request is taken; leave it high on return.
  task automatic send_request(input bit restart);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.restart = restart;
    @(negedge clk);
    while (!in_taken) @(negedge clk);
  endtask

  // Wait until every predicted result is out and the block has gone quiet.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = index;
    cfg_ch.data  = data;
    @(negedge clk);
    while (!cfg_taken) @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] n, input logic [CFG_DATA_W-1:0] k,
                           input bit chosen_first);
    drain();
    if (chosen_first) begin
      write_reg(REG_CHOSEN, k);
      write_reg(REG_TOTAL, n);
    end else begin
      write_reg(REG_TOTAL, n);
      write_reg(REG_CHOSEN, k);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] n_sel;
    logic [CFG_DATA_W-1:0] k_sel;
    int unsigned           kind;
    int unsigned           burst;
    int unsigned           j;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_TOTAL;
    cfg_ch.data   = '0;
    in_idle_pct   = 25;
    out_stall_pct = 52;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset setup is n=1, k=1
    send_request(ADVANCE);
    send_request(RESTART);
    send_request(ADVANCE);
    configure(7'd64, 7'd16, 1'b0);
    send_request(RESTART);
    send_request(ADVANCE);
    send_request(ADVANCE);
    configure(7'd16, 7'd16, 1'b1);
    send_request(RESTART);
    send_request(ADVANCE);
    // illegal setups: k too large, k zero, n zero, n too large, k above n
    configure(7'd5, 7'd17, 1'b0);
    send_request(RESTART);
    send_request(ADVANCE);
    configure(7'd5, 7'd0, 1'b0);
    send_request(RESTART);
    configure(7'd0, 7'd1, 1'b0);
    send_request(RESTART);
    configure(7'd100, 7'd1, 1'b0);
    send_request(RESTART);
    configure(7'd3, 7'd5, 1'b1);
    send_request(RESTART);
    configure(7'd127, 7'd127, 1'b0);
    send_request(RESTART);
    // unknown register indexes must not drop the running enumeration
    configure(7'd5, 7'd2, 1'b0);
    send_request(RESTART);
    drain();
    write_reg(REG_SPARE_2, 7'h7F);
    write_reg(REG_SPARE_3, 7'h2A);
    repeat (10) send_request(ADVANCE);

    random_sent = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        n_sel = CFG_DATA_W'($urandom_range(1, 9));
        k_sel = CFG_DATA_W'($urandom_range(1, n_sel));
        burst = $urandom_range(2, 24);
      end else if (kind < 70) begin
        n_sel = CFG_DATA_W'($urandom_range(10, 64));
        k_sel = CFG_DATA_W'($urandom_range(1, 16));
        if (k_sel > n_sel) k_sel = n_sel;
        burst = $urandom_range(2, 16);
      end else if (kind < 76) begin
        n_sel = 7'd64;
        k_sel = 7'd1;
        burst = 66;
      end else if (kind < 80) begin
        n_sel = 7'd64;
        k_sel = 7'd16;
        burst = 52;
      end else if (kind < 86) begin
        n_sel = CFG_DATA_W'($urandom_range(1, 16));
        k_sel = n_sel;
        burst = 3;
      end else begin
        n_sel = CFG_DATA_W'($urandom_range(0, 127));
        k_sel = CFG_DATA_W'($urandom_range(0, 127));
        burst = $urandom_range(1, 3);
      end
      configure(n_sel, k_sel, 1'($urandom_range(1)));
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(127)));
      for (j = 0; j < burst && random_sent < RANDOM_REQUESTS; j++) begin
        case (random_sent * 3 / RANDOM_REQUESTS)
          0: begin
            in_idle_pct   = 25;
            out_stall_pct = 52;
          end
          1: begin
            in_idle_pct   = 52;
            out_stall_pct = 25;
          end
          default: begin
            in_idle_pct   = 0;
            out_stall_pct = 0;
          end
        endcase
        if ($urandom_range(24) == 0)
          drain();
        // mostly restart first, then advance, with the odd restart mid-run
        if (j == 0)
          send_request($urandom_range(19) != 0);
        else
          send_request($urandom_range(99) < 8);
        random_sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("combination_enumerator regression: pass");
    end else begin
      $display("combination_enumerator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/cmbe_pkg.sv
design/cmbe_if.sv
design/cmbe_mem.sv
design/cmbe_seq.sv
design/combination_enumerator.sv
sim/combination_enumerator_checker.sv
sim/combination_enumerator_test.sv
